/* design/vpa_pkg.sv */
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants for the variable partition allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package vpa_pkg;

   localparam int FREE_ENTRIES_DEF = 16;
   localparam int USED_ENTRIES_DEF = 16;
   localparam int ADDR_BITS_DEF    = 16;
   localparam logic [15:0] TOTAL_RESET = 16'd1024;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOFIT   = 3'd1;
   localparam logic [2:0] ST_NOID    = 3'd2;
   localparam logic [2:0] ST_BADSIZE = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [1:0] MODE_FIRST = 2'd0;
   localparam logic [1:0] MODE_BEST  = 2'd1;
   localparam logic [1:0] MODE_WORST = 2'd2;

   localparam logic REG_TOTAL = 1'b0;
   localparam logic REG_MODE  = 1'b1;

   typedef struct packed {
      logic        func;
      logic [15:0] req_size;
      logic [15:0] kill_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] block_id;
      logic [15:0] base_addr;
      logic [15:0] block_size;
   } rsp_type;

endpackage

`default_nettype wire

/* design/variable_partition_allocator.sv */
// ----------------------------------------------------------------------------
// variable_partition_allocator
// First / best / worst fit allocator over an address-sorted free table.
// ----------------------------------------------------------------------------
// channel  ports                         handshake
// req      start busy req_data           start & !busy
// rsp      rsp_valid rsp_data            strobe, one cycle, no backpressure
// csr      csr_valid csr_ready csr_index csr_data   valid & ready
//
// An item walks the tables one entry per cycle through a single compare
// unit: an allocate scans the free table, then inserts into the used table;
// a free finds and deletes its used entry, then inserts a free entry.
// Table shifts move one entry per cycle. Reset is synchronous and leaves
// one free extent of 1024. The result strobe cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_partition_allocator #(
   parameter int FREE_ENTRIES = vpa_pkg::FREE_ENTRIES_DEF,
   parameter int USED_ENTRIES = vpa_pkg::USED_ENTRIES_DEF,
   parameter int ADDR_BITS    = vpa_pkg::ADDR_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire vpa_pkg::req_type req_data,
   output logic                  rsp_valid,
   output vpa_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [15:0]      csr_data
);

   localparam int FW = $clog2(FREE_ENTRIES);
   localparam int UW = $clog2(USED_ENTRIES);
   localparam int FC = $clog2(FREE_ENTRIES + 1);
   localparam int UC = $clog2(USED_ENTRIES + 1);
   localparam int A  = ADDR_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_FREE_SH, S_USED_POS, S_USED_SH, S_USED_PUT,
      S_FIND, S_USED_DEL, S_FREE_POS, S_FREE_INS, S_FREE_PUT, S_DONE
   } state_type;

   state_type        state_ff;
   logic [A-1:0]     fs_ff [FREE_ENTRIES];
   logic [A-1:0]     fl_ff [FREE_ENTRIES];
   logic [15:0]      ui_ff [USED_ENTRIES];
   logic [A-1:0]     us_ff [USED_ENTRIES];
   logic [A-1:0]     ul_ff [USED_ENTRIES];
   logic [FC-1:0]    fcnt_ff;
   logic [UC-1:0]    ucnt_ff;
   logic [15:0]      idc_ff;
   logic [1:0]       mode_ff;
   logic [FC-1:0]    fi_ff;
   logic [UC-1:0]    ui_idx_ff;
   logic [UC-1:0]    uj_ff;
   logic [FC-1:0]    best_ff;
   logic [A-1:0]     bleft_ff;
   logic             found_ff;
   logic [A-1:0]     size_ff;
   logic [A-1:0]     addr_ff;
   logic [15:0]      id_ff;
   vpa_pkg::rsp_type rsp_ff;
   logic             rv_ff;

   // shared unit: one subtract and compare per cycle
   logic [A-1:0] cur_len, left;
   logic         fits, better;
   always_comb begin
      cur_len = fl_ff[fi_ff[FW-1:0]];
      fits    = cur_len >= size_ff;
      left    = cur_len - size_ff;
      better  = !found_ff ||
                (mode_ff == vpa_pkg::MODE_BEST  && left < bleft_ff) ||
                (mode_ff == vpa_pkg::MODE_WORST && left > bleft_ff);
   end

   assign busy      = state_ff != S_IDLE;
   assign csr_ready = state_ff == S_IDLE && !start;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff    <= 1'b0;
         state_ff <= S_IDLE;
         fs_ff[0] <= '0;
         fl_ff[0] <= A'(vpa_pkg::TOTAL_RESET);
         fcnt_ff  <= FC'(1);
         ucnt_ff  <= '0;
         idc_ff   <= '0;
         mode_ff  <= vpa_pkg::MODE_FIRST;
      end else begin
         rv_ff <= state_ff == S_DONE;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  size_ff   <= A'(req_data.req_size);
                  fi_ff     <= '0;
                  ui_idx_ff <= '0;
                  found_ff  <= 1'b0;
                  if (req_data.func == vpa_pkg::FUNC_FREE) begin
                     id_ff    <= req_data.kill_id;
                     state_ff <= S_FIND;
                  end else if (A'(req_data.req_size) == '0) begin
                     rsp_ff   <= '{vpa_pkg::ST_BADSIZE, 16'd0, 16'd0, 16'd0};
                     state_ff <= S_DONE;
                  end else begin
                     idc_ff <= idc_ff + 16'd1;
                     id_ff  <= idc_ff + 16'd1;
                     if (ucnt_ff >= UC'(USED_ENTRIES)) begin
                        rsp_ff   <= '{vpa_pkg::ST_FULL, idc_ff + 16'd1, 16'd0, 16'd0};
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_SCAN;
                     end
                  end
               end else if (csr_valid) begin
                  if (csr_index == vpa_pkg::REG_TOTAL) begin
                     fs_ff[0] <= '0;
                     fl_ff[0] <= A'(csr_data);
                     fcnt_ff  <= (A'(csr_data) != '0) ? FC'(1) : FC'(0);
                     ucnt_ff  <= '0;
                  end else begin
                     mode_ff <= csr_data[1:0];
                  end
               end
            end
            S_SCAN: begin
               if (fi_ff >= fcnt_ff || (found_ff && mode_ff != vpa_pkg::MODE_BEST &&
                                        mode_ff != vpa_pkg::MODE_WORST)) begin
                  if (!found_ff) begin
                     rsp_ff   <= '{vpa_pkg::ST_NOFIT, id_ff, 16'd0, 16'd0};
                     state_ff <= S_DONE;
                  end else begin
                     addr_ff <= fs_ff[best_ff[FW-1:0]];
                     if (fl_ff[best_ff[FW-1:0]] == size_ff) begin
                        fi_ff    <= best_ff;
                        state_ff <= S_FREE_SH;
                     end else begin
                        fs_ff[best_ff[FW-1:0]] <= fs_ff[best_ff[FW-1:0]] + size_ff;
                        fl_ff[best_ff[FW-1:0]] <= fl_ff[best_ff[FW-1:0]] - size_ff;
                        state_ff <= S_USED_POS;
                     end
                  end
               end else begin
                  if (fits && better) begin
                     found_ff <= 1'b1;
                     best_ff  <= fi_ff;
                     bleft_ff <= left;
                  end
                  fi_ff <= fi_ff + FC'(1);
               end
            end
            S_FREE_SH: begin
               if (fi_ff + FC'(1) < fcnt_ff) begin
                  fs_ff[fi_ff[FW-1:0]] <= fs_ff[FW'(fi_ff + FC'(1))];
                  fl_ff[fi_ff[FW-1:0]] <= fl_ff[FW'(fi_ff + FC'(1))];
                  fi_ff <= fi_ff + FC'(1);
               end else begin
                  fcnt_ff  <= fcnt_ff - FC'(1);
                  state_ff <= S_USED_POS;
               end
            end
            S_USED_POS: begin
               if (ui_idx_ff < ucnt_ff && us_ff[ui_idx_ff[UW-1:0]] <= addr_ff) begin
                  ui_idx_ff <= ui_idx_ff + UC'(1);
               end else begin
                  uj_ff    <= ucnt_ff;
                  state_ff <= S_USED_SH;
               end
            end
            S_USED_SH: begin
               // uj_ff walks down from the count to the insert point
               if (uj_ff > ui_idx_ff) begin
                  ui_ff[uj_ff[UW-1:0]] <= ui_ff[UW'(uj_ff - UC'(1))];
                  us_ff[uj_ff[UW-1:0]] <= us_ff[UW'(uj_ff - UC'(1))];
                  ul_ff[uj_ff[UW-1:0]] <= ul_ff[UW'(uj_ff - UC'(1))];
                  uj_ff <= uj_ff - UC'(1);
               end else begin
                  state_ff <= S_USED_PUT;
               end
            end
            S_USED_PUT: begin
               ui_ff[ui_idx_ff[UW-1:0]] <= id_ff;
               us_ff[ui_idx_ff[UW-1:0]] <= addr_ff;
               ul_ff[ui_idx_ff[UW-1:0]] <= size_ff;
               ucnt_ff  <= ucnt_ff + UC'(1);
               rsp_ff   <= '{vpa_pkg::ST_OK, id_ff, 16'(addr_ff), 16'(size_ff)};
               state_ff <= S_DONE;
            end
            S_FIND: begin
               if (ui_idx_ff >= ucnt_ff) begin
                  rsp_ff   <= '{vpa_pkg::ST_NOID, id_ff, 16'd0, 16'd0};
                  state_ff <= S_DONE;
               end else if (ui_ff[ui_idx_ff[UW-1:0]] == id_ff) begin
                  addr_ff <= us_ff[ui_idx_ff[UW-1:0]];
                  size_ff <= ul_ff[ui_idx_ff[UW-1:0]];
                  if (fcnt_ff >= FC'(FREE_ENTRIES)) begin
                     rsp_ff <= '{vpa_pkg::ST_FULL, id_ff,
                                 16'(us_ff[ui_idx_ff[UW-1:0]]),
                                 16'(ul_ff[ui_idx_ff[UW-1:0]])};
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_USED_DEL;
                  end
               end else begin
                  ui_idx_ff <= ui_idx_ff + UC'(1);
               end
            end
            S_USED_DEL: begin
               if (ui_idx_ff + UC'(1) < ucnt_ff) begin
                  ui_ff[ui_idx_ff[UW-1:0]] <= ui_ff[UW'(ui_idx_ff + UC'(1))];
                  us_ff[ui_idx_ff[UW-1:0]] <= us_ff[UW'(ui_idx_ff + UC'(1))];
                  ul_ff[ui_idx_ff[UW-1:0]] <= ul_ff[UW'(ui_idx_ff + UC'(1))];
                  ui_idx_ff <= ui_idx_ff + UC'(1);
               end else begin
                  ucnt_ff  <= ucnt_ff - UC'(1);
                  fi_ff    <= '0;
                  state_ff <= S_FREE_POS;
               end
            end
            S_FREE_POS: begin
               if (fi_ff < fcnt_ff && fs_ff[fi_ff[FW-1:0]] <= addr_ff) begin
                  fi_ff <= fi_ff + FC'(1);
               end else begin
                  best_ff  <= fcnt_ff;
                  state_ff <= S_FREE_INS;
               end
            end
            S_FREE_INS: begin
               // best_ff walks down from the count to the insert point
               if (best_ff > fi_ff) begin
                  fs_ff[best_ff[FW-1:0]] <= fs_ff[FW'(best_ff - FC'(1))];
                  fl_ff[best_ff[FW-1:0]] <= fl_ff[FW'(best_ff - FC'(1))];
                  best_ff <= best_ff - FC'(1);
               end else begin
                  state_ff <= S_FREE_PUT;
               end
            end
            S_FREE_PUT: begin
               fs_ff[fi_ff[FW-1:0]] <= addr_ff;
               fl_ff[fi_ff[FW-1:0]] <= size_ff;
               fcnt_ff  <= fcnt_ff + FC'(1);
               rsp_ff   <= '{vpa_pkg::ST_OK, id_ff, 16'(addr_ff), 16'(size_ff)};
               state_ff <= S_DONE;
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the variable partition allocator: a directed table,
// a mode sweep, random allocate/free traffic; a fit-rule predictor checks all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int NFREE = vpa_pkg::FREE_ENTRIES_DEF;
   localparam int NUSED = vpa_pkg::USED_ENTRIES_DEF;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   vpa_pkg::req_type req_data = '0;
   logic             rsp_valid;
   vpa_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_index = vpa_pkg::REG_TOTAL;
   logic [15:0]      csr_data = '0;

   variable_partition_allocator DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // allocator shadow state
   logic [15:0] mem_total;
   logic [1:0]  mode;
   logic [15:0] hole_addr [NFREE];
   logic [15:0] hole_len  [NFREE];
   int          hole_cnt;
   logic [15:0] blk_id    [NUSED];
   logic [15:0] blk_addr  [NUSED];
   logic [15:0] blk_len   [NUSED];
   int          blk_cnt;
   logic [15:0] next_id;

   vpa_pkg::rsp_type pending_rsp [$];
   int               errors = 0;

   typedef struct {
      logic             func;
      logic [15:0]      size;
      logic [15:0]      id;
      bit               fixed;
      vpa_pkg::rsp_type want;
   } row_type;

   function automatic void clear_tables();
      blk_cnt = 0;
      hole_addr[0] = 16'd0;
      hole_len[0] = mem_total;
      hole_cnt = (mem_total != 16'd0) ? 1 : 0;
   endfunction

   function automatic vpa_pkg::rsp_type allocate_block(logic [15:0] size);
      vpa_pkg::rsp_type r;
      int k;
      logic [15:0] left, best_left;
      logic [15:0] a;
      int pos;
      r = '0;
      if (size == 16'd0) begin
         r.status = vpa_pkg::ST_BADSIZE;
         return r;
      end
      next_id = next_id + 16'd1;
      r.block_id = next_id;
      if (blk_cnt >= NUSED) begin
         r.status = vpa_pkg::ST_FULL;
         return r;
      end
      k = hole_cnt;
      best_left = 16'd0;
      for (int i = 0; i < hole_cnt; i++) begin
         if (hole_len[i] < size) continue;
         left = hole_len[i] - size;
         if (k == hole_cnt) begin
            k = i;
            best_left = left;
            if (mode != vpa_pkg::MODE_BEST && mode != vpa_pkg::MODE_WORST) break;
         end else if (mode == vpa_pkg::MODE_BEST && left < best_left) begin
            k = i;
            best_left = left;
         end else if (mode == vpa_pkg::MODE_WORST && left > best_left) begin
            k = i;
            best_left = left;
         end
      end
      if (k >= hole_cnt) begin
         r.status = vpa_pkg::ST_NOFIT;
         return r;
      end
      a = hole_addr[k];
      if (hole_len[k] == size) begin
         for (int j = k; j + 1 < hole_cnt; j++) begin
            hole_addr[j] = hole_addr[j+1];
            hole_len[j] = hole_len[j+1];
         end
         hole_cnt--;
      end else begin
         hole_addr[k] = a + size;
         hole_len[k] = hole_len[k] - size;
      end
      pos = 0;
      while (pos < blk_cnt && blk_addr[pos] <= a) pos++;
      for (int j = blk_cnt; j > pos; j--) begin
         blk_id[j] = blk_id[j-1];
         blk_addr[j] = blk_addr[j-1];
         blk_len[j] = blk_len[j-1];
      end
      blk_id[pos] = next_id;
      blk_addr[pos] = a;
      blk_len[pos] = size;
      blk_cnt++;
      r.status = vpa_pkg::ST_OK;
      r.base_addr = a;
      r.block_size = size;
      return r;
   endfunction

   function automatic vpa_pkg::rsp_type release_block(logic [15:0] id);
      vpa_pkg::rsp_type r;
      int u;
      int pos;
      logic [15:0] a, n;
      r = '0;
      r.block_id = id;
      u = 0;
      while (u < blk_cnt && blk_id[u] != id) u++;
      if (u >= blk_cnt) begin
         r.status = vpa_pkg::ST_NOID;
         return r;
      end
      a = blk_addr[u];
      n = blk_len[u];
      r.base_addr = a;
      r.block_size = n;
      if (hole_cnt >= NFREE) begin
         r.status = vpa_pkg::ST_FULL;
         return r;
      end
      for (int j = u; j + 1 < blk_cnt; j++) begin
         blk_id[j] = blk_id[j+1];
         blk_addr[j] = blk_addr[j+1];
         blk_len[j] = blk_len[j+1];
      end
      blk_cnt--;
      pos = 0;
      while (pos < hole_cnt && hole_addr[pos] <= a) pos++;
      for (int j = hole_cnt; j > pos; j--) begin
         hole_addr[j] = hole_addr[j-1];
         hole_len[j] = hole_len[j-1];
      end
      hole_addr[pos] = a;
      hole_len[pos] = n;
      hole_cnt++;
      r.status = vpa_pkg::ST_OK;
      return r;
   endfunction

   // one transaction; start stays high unless gaps are on and a random idle gap is drawn
   task automatic send_req(logic func, logic [15:0] size, logic [15:0] id,
                           bit fixed, vpa_pkg::rsp_type want, bit gaps);
      vpa_pkg::rsp_type r;
      vpa_pkg::req_type q;
      q.func = func;
      q.req_size = size;
      q.kill_id = id;
      start <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = func == vpa_pkg::FUNC_FREE ? release_block(id) : allocate_block(size);
      if (fixed && r !== want) begin
         $display("%0t table row: expected %p actual predictor %p", $time, want, r);
         errors++;
      end
      pending_rsp.push_back(r);
      if (gaps && $urandom_range(99) < 17) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == vpa_pkg::REG_TOTAL) begin
         mem_total = value;
         clear_tables();
      end else begin
         mode = value[1:0];
      end
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected response: expected none actual %p", $time, rsp_data);
            errors++;
         end else begin
            vpa_pkg::rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_data.status !== e.status)
               $display("%0t status: expected %0d actual %0d", $time, e.status,
                        rsp_data.status);
            if (rsp_data.block_id !== e.block_id)
               $display("%0t block_id: expected %0d actual %0d", $time, e.block_id,
                        rsp_data.block_id);
            if (rsp_data.base_addr !== e.base_addr)
               $display("%0t base_addr: expected %0d actual %0d", $time,
                        e.base_addr, rsp_data.base_addr);
            if (rsp_data.block_size !== e.block_size)
               $display("%0t block_size: expected %0d actual %0d", $time,
                        e.block_size, rsp_data.block_size);
            if (rsp_data !== e) errors++;
         end
      end
   end

   function automatic row_type mk(logic f, logic [15:0] s, logic [15:0] i, bit fx,
                                  logic [2:0] st, logic [15:0] bi, logic [15:0] sa,
                                  logic [15:0] bs);
      row_type r;
      r.func = f; r.size = s; r.id = i; r.fixed = fx;
      r.want.status = st; r.want.block_id = bi;
      r.want.base_addr = sa; r.want.block_size = bs;
      return r;
   endfunction

   initial begin
      row_type     rows [$];
      logic [15:0] live [$];
      logic [15:0] size;
      bit          gaps;
      mem_total = vpa_pkg::TOTAL_RESET;
      mode = vpa_pkg::MODE_FIRST;
      next_id = 16'd0;
      clear_tables();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: one extent of 1024 at address zero
      rows.push_back(mk(vpa_pkg::FUNC_ALLOC, 16'd0, 16'd0, 1'b1, vpa_pkg::ST_BADSIZE,
                        16'd0, 16'd0, 16'd0));
      rows.push_back(mk(vpa_pkg::FUNC_ALLOC, 16'd100, 16'd0, 1'b1, vpa_pkg::ST_OK,
                        16'd1, 16'd0, 16'd100));
      rows.push_back(mk(vpa_pkg::FUNC_ALLOC, 16'hFFFF, 16'd0, 1'b1, vpa_pkg::ST_NOFIT,
                        16'd2, 16'd0, 16'd0));
      rows.push_back(mk(vpa_pkg::FUNC_ALLOC, 16'd924, 16'd0, 1'b1, vpa_pkg::ST_OK,
                        16'd3, 16'd100, 16'd924));
      rows.push_back(mk(vpa_pkg::FUNC_FREE, 16'd0, 16'hFFFF, 1'b1, vpa_pkg::ST_NOID,
                        16'hFFFF, 16'd0, 16'd0));
      rows.push_back(mk(vpa_pkg::FUNC_FREE, 16'hFFFF, 16'd1, 1'b1, vpa_pkg::ST_OK,
                        16'd1, 16'd0, 16'd100));
      rows.push_back(mk(vpa_pkg::FUNC_ALLOC, 16'd1, 16'hFFFF, 1'b1, vpa_pkg::ST_OK,
                        16'd4, 16'd0, 16'd1));
      rows.push_back(mk(vpa_pkg::FUNC_FREE, 16'd0, 16'd3, 1'b1, vpa_pkg::ST_OK,
                        16'd3, 16'd100, 16'd924));
      rows.push_back(mk(vpa_pkg::FUNC_FREE, 16'd0, 16'd3, 1'b1, vpa_pkg::ST_NOID,
                        16'd3, 16'd0, 16'd0));
      for (int i = 0; i < 16; i++)
         rows.push_back(mk(vpa_pkg::FUNC_ALLOC, 16'd2, 16'd0, 1'b0, vpa_pkg::ST_OK,
                           16'd0, 16'd0, 16'd0));
      foreach (rows[i])
         send_req(rows[i].func, rows[i].size, rows[i].id, rows[i].fixed,
                  rows[i].want, 1'b0);
      drain();

      // fragment the table and drive the free table full
      for (int m = 0; m < 4; m++) begin
         write_reg(vpa_pkg::REG_MODE, 16'(m));
         write_reg(vpa_pkg::REG_TOTAL, m == 0 ? 16'hFFFF : (m == 1 ? 16'd1 : 16'd300));
         for (int i = 0; i < 16; i++)
            send_req(vpa_pkg::FUNC_ALLOC, 16'($urandom_range(1, 30)), 16'd0, 1'b0, '0,
                     1'b1);
         for (int i = 0; i <= 16; i++)
            send_req(vpa_pkg::FUNC_FREE, 16'd0, next_id - 16'(i), 1'b0, '0, 1'b1);
         send_req(vpa_pkg::FUNC_ALLOC, 16'd5, 16'd0, 1'b0, '0, 1'b1);
         drain();
      end
      write_reg(vpa_pkg::REG_TOTAL, 16'd0);
      send_req(vpa_pkg::FUNC_ALLOC, 16'd1, 16'd0, 1'b0, '0, 1'b0);
      drain();

      // random traffic, mostly well-formed alloc/free of live ids
      for (int i = 0; i < 800; i++) begin
         if (i % 150 == 0) begin
            drain();
            write_reg(vpa_pkg::REG_MODE, 16'($urandom_range(0, 3)));
            write_reg(vpa_pkg::REG_TOTAL,
                      i == 300 ? 16'hFFFF : 16'($urandom_range(1, 2000)));
         end
         gaps = !(i >= 450 && i < 600);
         live.delete();
         for (int b = 0; b < blk_cnt; b++) live.push_back(blk_id[b]);
         if (live.size() != 0 && $urandom_range(99) < 45) begin
            send_req(vpa_pkg::FUNC_FREE, 16'($urandom),
                     $urandom_range(99) < 90 ? live[$urandom_range(live.size()-1)]
                                             : 16'($urandom), 1'b0, '0, gaps);
         end else begin
            case ($urandom_range(9))
               0: size = 16'($urandom);
               1: size = 16'd0;
               default: size = 16'($urandom_range(1, 120));
            endcase
            send_req(vpa_pkg::FUNC_ALLOC, size, 16'($urandom), 1'b0, '0, gaps);
         end
      end
      drain();

      if (errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb NOT OK");
      $finish;
   end

endmodule

/* variable_partition_allocator.f */
design/vpa_pkg.sv
design/variable_partition_allocator.sv
dv/tb.sv
